FILE: rtl/ccm_pkg.sv
package ccm_pkg;

    // Default parameter values
    localparam int DEF_CHANNEL_BITS = 16;
    localparam int DEF_FRAC_BITS    = 16;

    // Port field widths
    localparam int CHAN_W = 16;
    localparam int TEMP_W = 16;
    localparam int LUX_W  = 16;

    // Tristimulus widths: X, Y, Z fit 32 bits signed, their sum 33 bits
    localparam int XY_W     = 32;
    localparam int XY_MAG_W = 31;
    localparam int S_W      = 33;
    localparam int S_MAG_W  = 32;
    localparam int LUX_SHIFT = 14;

    // Chromaticity quotient bits (saturates at 2^31-1)
    localparam int XC_QB = 31;

    // xc - K1 and K2 - yc
    localparam int CH_W     = 33;
    localparam int CH_MAG_W = 32;

    // Q2.14 matrix, rows X, Y, Z, columns r, g, b
    localparam logic signed [XY_W-1:0] M_XR = -32'sd2340;
    localparam logic signed [XY_W-1:0] M_XG =  32'sd25383;
    localparam logic signed [XY_W-1:0] M_XB = -32'sd15670;
    localparam logic signed [XY_W-1:0] M_YR = -32'sd5319;
    localparam logic signed [XY_W-1:0] M_YG =  32'sd25860;
    localparam logic signed [XY_W-1:0] M_YB = -32'sd11992;
    localparam logic signed [XY_W-1:0] M_ZR = -32'sd11174;
    localparam logic signed [XY_W-1:0] M_ZG =  32'sd12628;
    localparam logic signed [XY_W-1:0] M_ZB =  32'sd9229;

    // McCamy cubic in hundredths of a kelvin
    localparam int C3_W = 16;
    localparam int C2_W = 19;
    localparam int C1_W = 20;
    localparam logic [C3_W-1:0] POLY_C3 = 16'd44900;
    localparam logic [C2_W-1:0] POLY_C2 = 19'd352500;
    localparam logic [C1_W-1:0] POLY_C1 = 20'd682330;
    localparam int              POLY_C0 = 552033;

    // Final scaling by 1/100 as a reciprocal multiply
    localparam int CCT_IN_W = 23;
    localparam int RECIP_W  = 24;
    localparam int RECIP_SH = 30;
    localparam logic [RECIP_W-1:0]  RECIP_100 = 24'd10737419;
    localparam logic [CCT_IN_W-1:0] CCT_LIM   = 23'd6553600;
    localparam logic [CCT_IN_W-1:0] NEG_LIM   = 23'd100;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LOW   = 2'd1,
        ST_HIGH  = 2'd2,
        ST_UNDEF = 2'd3
    } ccm_status_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } ccm_pix_t;

    typedef struct packed {
        logic [TEMP_W-1:0] color_temp;
        ccm_status_t       temp_status;
        logic [LUX_W-1:0]  lux;
        logic              lux_clamped;
    } ccm_res_t;

    typedef struct packed {
        logic [LUX_W-1:0] lux;
        logic             clamped;
    } ccm_lux_t;

    typedef struct packed {
        logic [XY_MAG_W-1:0] x_mag;
        logic                x_neg;
        logic [XY_MAG_W-1:0] y_mag;
        logic                y_neg;
        logic [S_MAG_W-1:0]  s_mag;
        logic                s_neg;
        ccm_lux_t            lux;
    } ccm_xyz_t;

    // Sideband that rides along a divider
    typedef struct packed {
        ccm_lux_t lux;
        logic     neg;
        logic     undef;
    } ccm_side_t;

endpackage

FILE: rtl/ccm_matrix.sv
module ccm_matrix
    import ccm_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     pix_valid,
    input  ccm_pix_t pix,
    output logic     xyz_valid,
    output ccm_xyz_t xyz
);

    localparam int LUX_Q_W = XY_MAG_W - LUX_SHIFT;

    logic                    v1_reg, v2_reg, v3_reg;
    logic [CHANNEL_BITS-1:0] r_reg, g_reg, b_reg;
    logic signed [XY_W-1:0]  x_reg, y_reg, z_reg;
    logic signed [XY_W-1:0]  x_next, y_next, z_next;
    ccm_xyz_t                xyz_reg, xyz_next;

    always_comb
    begin
        logic signed [XY_W-1:0] rs, gs, bs;
        rs = $signed({{(XY_W-CHANNEL_BITS){1'b0}}, r_reg});
        gs = $signed({{(XY_W-CHANNEL_BITS){1'b0}}, g_reg});
        bs = $signed({{(XY_W-CHANNEL_BITS){1'b0}}, b_reg});
        x_next = rs * M_XR + gs * M_XG + bs * M_XB;
        y_next = rs * M_YR + gs * M_YG + bs * M_YB;
        z_next = rs * M_ZR + gs * M_ZG + bs * M_ZB;
    end

    always_comb
    begin
        logic signed [S_W-1:0]  s_sum, s_abs;
        logic signed [XY_W-1:0] x_abs, y_abs;
        logic [LUX_Q_W-1:0]     lux_q;
        s_sum = S_W'(x_reg) + S_W'(y_reg) + S_W'(z_reg);
        s_abs = s_sum[S_W-1] ? -s_sum : s_sum;
        x_abs = x_reg[XY_W-1] ? -x_reg : x_reg;
        y_abs = y_reg[XY_W-1] ? -y_reg : y_reg;
        lux_q = y_abs[XY_MAG_W-1:LUX_SHIFT];
        xyz_next.x_mag = x_abs[XY_MAG_W-1:0];
        xyz_next.x_neg = x_reg[XY_W-1];
        xyz_next.y_mag = y_abs[XY_MAG_W-1:0];
        xyz_next.y_neg = y_reg[XY_W-1];
        xyz_next.s_mag = s_abs[S_MAG_W-1:0];
        xyz_next.s_neg = s_sum[S_W-1];
        // truncate toward zero, clamp to 0..65535
        if (y_reg[XY_W-1])
        begin
            xyz_next.lux.lux     = '0;
            xyz_next.lux.clamped = (lux_q != '0);
        end
        else if (lux_q[LUX_Q_W-1])
        begin
            xyz_next.lux.lux     = '1;
            xyz_next.lux.clamped = 1'b1;
        end
        else
        begin
            xyz_next.lux.lux     = lux_q[LUX_W-1:0];
            xyz_next.lux.clamped = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pix_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= pix.red[CHANNEL_BITS-1:0];
            g_reg   <= pix.green[CHANNEL_BITS-1:0];
            b_reg   <= pix.blue[CHANNEL_BITS-1:0];
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            xyz_reg <= xyz_next;
        end
    end

    assign xyz_valid = v3_reg;
    assign xyz       = xyz_reg;

endmodule

FILE: rtl/ccm_div.sv
module ccm_div
    import ccm_pkg::*;
#(
    parameter int NUM_W = 47,
    parameter int DEN_W = 32,
    parameter int QB    = 31,
    parameter int SW    = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SW-1:0]    side_in,
    output logic             out_valid,
    output logic [QB-1:0]    quo,
    output logic             ovf,
    output logic             dz,
    output logic [SW-1:0]    side_out
);

    localparam int HI_W  = NUM_W - QB;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic             vld_reg  [QB+1];
    logic [DEN_W-1:0] rem_reg  [QB+1];
    logic [DEN_W-1:0] rem_next [QB+1];
    logic [QB-1:0]    low_reg  [QB+1];
    logic [QB-1:0]    low_next [QB+1];
    logic [QB-1:0]    quo_reg  [QB+1];
    logic [QB-1:0]    quo_next [QB+1];
    logic [DEN_W-1:0] den_reg  [QB+1];
    logic             ovf_reg  [QB+1];
    logic             dz_reg   [QB+1];
    logic [SW-1:0]    side_reg [QB+1];
    logic             ovf_reg_in;

    // one quotient bit per stage, restoring
    always_comb
    begin
        logic [CMP_W-1:0] hi_ext, den_ext;
        logic [DEN_W:0]   trial, diff;
        logic             ge;
        hi_ext      = CMP_W'(num[NUM_W-1:QB]);
        den_ext     = CMP_W'(den);
        rem_next[0] = hi_ext[DEN_W-1:0];
        low_next[0] = num[QB-1:0];
        quo_next[0] = '0;
        for (int k = 1; k <= QB; k++)
        begin
            trial       = {rem_reg[k-1], low_reg[k-1][QB-1]};
            diff        = trial - {1'b0, den_reg[k-1]};
            ge          = (trial >= {1'b0, den_reg[k-1]});
            rem_next[k] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_next[k] = low_reg[k-1] << 1;
            quo_next[k] = {quo_reg[k-1][QB-2:0], ge};
        end
        // quotient would need more than QB bits
        ovf_reg_in = (hi_ext >= den_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= QB; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0]  <= ovf_reg_in;
            dz_reg[0]   <= (den == '0);
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            for (int k = 0; k <= QB; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                quo_reg[k] <= quo_next[k];
            end
            for (int k = 1; k <= QB; k++)
            begin
                ovf_reg[k]  <= ovf_reg[k-1];
                dz_reg[k]   <= dz_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign quo       = quo_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign dz        = dz_reg[QB];
    assign side_out  = side_reg[QB];

endmodule

FILE: rtl/ccm_poly.sv
module ccm_poly
    import ccm_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [FRAC_BITS+6:0] q,
    input  logic                 ovf,
    input  logic                 dz,
    input  ccm_side_t            side,
    output logic                 res_valid,
    output ccm_res_t             res
);

    localparam int NB   = FRAC_BITS + 7;
    localparam int N2W  = FRAC_BITS + 14;
    localparam int LO_W = N2W / 2;
    localparam int HI_W = N2W - LO_W;
    localparam int N3W  = FRAC_BITS + 21;
    localparam int PW   = FRAC_BITS + 38;
    localparam int PM_W = PW - 1 - FRAC_BITS;
    localparam int T3_W = N3W + C3_W;
    localparam int T2_W = N2W + C2_W;
    localparam int T1_W = NB + C1_W;
    localparam int NSTG = 8;
    localparam logic [NB-1:0]        N_SAT = NB'(127) << FRAC_BITS;
    localparam logic signed [PW-1:0] P_OFS = PW'(POLY_C0) << FRAC_BITS;

    logic             vld_reg  [NSTG];
    logic             ns_reg   [NSTG];
    logic             und_reg  [NSTG];
    ccm_lux_t         lux_reg  [NSTG];

    logic [NB-1:0]    nm_reg   [4];
    logic [N2W-1:0]   n2m_reg  [1:3];
    logic [NB-1:0]    nm0_next;
    logic [N2W-1:0]   n2m_next;
    logic [LO_W+NB-1:0] pl_reg, pl_next;
    logic [HI_W+NB-1:0] ph_reg, ph_next;
    logic [N3W-1:0]   n3m_reg, n3m_next;
    logic [T3_W-1:0]  t3_reg;
    logic [T2_W-1:0]  t2_reg;
    logic [T1_W-1:0]  t1_reg;
    logic signed [PW-1:0] p_reg, p_next;
    logic             p_neg_reg;
    logic             big_hi_reg, big_hi_next;
    logic             big_neg_reg, big_neg_next;
    logic [CCT_IN_W-1:0] mc_reg, mc_next;
    ccm_res_t         res_reg, res_next;

    always_comb
    begin
        logic [2*NB-1:0]      sq;
        logic [N2W+NB-1:0]    acc;
        logic signed [PW-1:0] e3, e1, pa;
        logic [PM_W-1:0]      pm;
        logic [CCT_IN_W+RECIP_W-1:0] prod;

        // clamp n to +-127
        nm0_next = (ovf || (q > N_SAT)) ? N_SAT : q;

        sq       = nm_reg[0] * nm_reg[0];
        n2m_next = sq[2*NB-1:FRAC_BITS];

        pl_next = n2m_reg[1][LO_W-1:0] * nm_reg[1];
        ph_next = n2m_reg[1][N2W-1:LO_W] * nm_reg[1];

        acc      = ((N2W+NB)'(ph_reg) << LO_W) + (N2W+NB)'(pl_reg);
        n3m_next = acc[N2W+NB-1:FRAC_BITS];

        // odd terms take the sign of n
        e3 = $signed(PW'(t3_reg));
        e1 = $signed(PW'(t1_reg));
        if (ns_reg[4])
        begin
            e3 = -e3;
            e1 = -e1;
        end
        p_next = P_OFS + $signed(PW'(t2_reg)) + e3 + e1;

        pa           = p_reg[PW-1] ? -p_reg : p_reg;
        pm           = pa[PW-2:FRAC_BITS];
        big_hi_next  = (pm >= PM_W'(CCT_LIM));
        big_neg_next = (pm >= PM_W'(NEG_LIM));
        mc_next      = pm[CCT_IN_W-1:0];

        prod = mc_reg * RECIP_100;
        res_next.lux         = lux_reg[6].lux;
        res_next.lux_clamped = lux_reg[6].clamped;
        if (und_reg[6])
        begin
            res_next.color_temp  = '0;
            res_next.temp_status = ST_UNDEF;
        end
        else if (p_neg_reg)
        begin
            res_next.color_temp  = '0;
            res_next.temp_status = big_neg_reg ? ST_LOW : ST_OK;
        end
        else if (big_hi_reg)
        begin
            res_next.color_temp  = '1;
            res_next.temp_status = ST_HIGH;
        end
        else
        begin
            res_next.color_temp  = prod[RECIP_SH +: TEMP_W];
            res_next.temp_status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTG; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NSTG; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ns_reg[0]  <= side.neg;
            und_reg[0] <= side.undef | dz;
            lux_reg[0] <= side.lux;
            for (int k = 1; k < NSTG; k++)
            begin
                ns_reg[k]  <= ns_reg[k-1];
                und_reg[k] <= und_reg[k-1];
                lux_reg[k] <= lux_reg[k-1];
            end
            nm_reg[0]   <= nm0_next;
            nm_reg[1]   <= nm_reg[0];
            nm_reg[2]   <= nm_reg[1];
            nm_reg[3]   <= nm_reg[2];
            n2m_reg[1]  <= n2m_next;
            n2m_reg[2]  <= n2m_reg[1];
            n2m_reg[3]  <= n2m_reg[2];
            pl_reg      <= pl_next;
            ph_reg      <= ph_next;
            n3m_reg     <= n3m_next;
            t3_reg      <= n3m_reg * POLY_C3;
            t2_reg      <= n2m_reg[3] * POLY_C2;
            t1_reg      <= nm_reg[3] * POLY_C1;
            p_reg       <= p_next;
            p_neg_reg   <= p_reg[PW-1];
            big_hi_reg  <= big_hi_next;
            big_neg_reg <= big_neg_next;
            mc_reg      <= mc_next;
            res_reg     <= res_next;
        end
    end

    assign res_valid = vld_reg[NSTG-1];
    assign res       = res_reg;

endmodule

FILE: rtl/rgb_color_temperature_mccamy_top.sv
// McCamy correlated color temperature and lux from one raw RGB triple.
// The pipeline depth is dominated by the two bit-per-stage dividers in series
//   (32 and FRAC_BITS+8 stages).
// Throughput: one request per cycle; the whole pipeline holds while res_stall
//   keeps a finished result waiting, and pix_stall is raised only then.
// Reset: rst_n clears all valid bits at once; data registers are not reset.
module rgb_color_temperature_mccamy_top
    import ccm_pkg::*;
#(
    parameter int CHANNEL_BITS = DEF_CHANNEL_BITS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pix_valid,
    output logic     pix_stall,
    input  ccm_pix_t pix,
    output logic     res_valid,
    input  logic     res_stall,
    output ccm_res_t res
);

    localparam int XC_NUM_W = XY_MAG_W + FRAC_BITS;
    localparam int N_NUM_W  = CH_MAG_W + FRAC_BITS;
    localparam int N_QB     = FRAC_BITS + 7;
    localparam int SIDE_W   = $bits(ccm_side_t);

    // rounded 0.3320 and 0.1858 in FRAC_BITS fraction bits
    localparam logic signed [CH_W-1:0] K1 =
        CH_W'((64'sd3320 * (64'sd1 <<< FRAC_BITS) + 64'sd5000) / 64'sd10000);
    localparam logic signed [CH_W-1:0] K2 =
        CH_W'((64'sd1858 * (64'sd1 <<< FRAC_BITS) + 64'sd5000) / 64'sd10000);

    logic adv;

    // Advance everything unless a finished result is held by the sink.
    assign adv       = !res_valid || !res_stall;
    assign pix_stall = !adv;

    // --------------------------------------------------------------
    // Matrix to XYZ, sum and lux (three stages)
    // --------------------------------------------------------------
    logic     xyz_valid;
    ccm_xyz_t xyz;

    ccm_matrix #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .pix_valid (pix_valid),
        .pix       (pix),
        .xyz_valid (xyz_valid),
        .xyz       (xyz)
    );

    // --------------------------------------------------------------
    // xc = X/S and yc = Y/S, one quotient bit per stage, side by side
    // --------------------------------------------------------------
    ccm_side_t            x_side_in, x_side_out;
    logic                 xd_valid;
    logic [XC_QB-1:0]     x_quo, y_quo;
    logic                 x_ovf, y_ovf, x_dz;
    logic [0:0]           y_side_out;

    assign x_side_in.lux   = xyz.lux;
    assign x_side_in.neg   = xyz.x_neg ^ xyz.s_neg;
    assign x_side_in.undef = 1'b0;

    ccm_div #(
        .NUM_W (XC_NUM_W),
        .DEN_W (S_MAG_W),
        .QB    (XC_QB),
        .SW    (SIDE_W)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (xyz_valid),
        .num       ({xyz.x_mag, {FRAC_BITS{1'b0}}}),
        .den       (xyz.s_mag),
        .side_in   (x_side_in),
        .out_valid (xd_valid),
        .quo       (x_quo),
        .ovf       (x_ovf),
        .dz        (x_dz),
        .side_out  (x_side_out)
    );

    ccm_div #(
        .NUM_W (XC_NUM_W),
        .DEN_W (S_MAG_W),
        .QB    (XC_QB),
        .SW    (1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (xyz_valid),
        .num       ({xyz.y_mag, {FRAC_BITS{1'b0}}}),
        .den       (xyz.s_mag),
        .side_in   (xyz.y_neg ^ xyz.s_neg),
        .out_valid (),
        .quo       (y_quo),
        .ovf       (y_ovf),
        .dz        (),
        .side_out  (y_side_out)
    );

    // --------------------------------------------------------------
    // Chromaticity: saturate and sign (stage C1), then form McCamy's
    // numerator xc - K1 and denominator K2 - yc as magnitudes (stage C2)
    // --------------------------------------------------------------
    logic                   c1_valid_reg, c2_valid_reg;
    logic signed [XY_W-1:0] xc_reg, yc_reg, xc_next, yc_next;
    ccm_side_t              c1_side_reg, c2_side_reg, c2_side_next;
    logic [CH_MAG_W-1:0]    a_mag_reg, d_mag_reg, a_mag_next, d_mag_next;

    always_comb
    begin
        logic [XY_MAG_W-1:0]    xm, ym;
        logic signed [XY_W-1:0] xs, ys;
        xm = x_ovf ? {XY_MAG_W{1'b1}} : x_quo;
        ym = y_ovf ? {XY_MAG_W{1'b1}} : y_quo;
        xs = $signed({1'b0, xm});
        ys = $signed({1'b0, ym});
        xc_next = x_side_out.neg ? -xs : xs;
        yc_next = y_side_out[0]  ? -ys : ys;
    end

    always_comb
    begin
        logic signed [CH_W-1:0] a_val, d_val, a_abs, d_abs;
        a_val = CH_W'(xc_reg) - K1;
        d_val = K2 - CH_W'(yc_reg);
        a_abs = a_val[CH_W-1] ? -a_val : a_val;
        d_abs = d_val[CH_W-1] ? -d_val : d_val;
        a_mag_next         = a_abs[CH_MAG_W-1:0];
        d_mag_next         = d_abs[CH_MAG_W-1:0];
        c2_side_next.lux   = c1_side_reg.lux;
        c2_side_next.neg   = a_val[CH_W-1] ^ d_val[CH_W-1];
        c2_side_next.undef = c1_side_reg.undef;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c1_valid_reg <= xd_valid;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xc_reg            <= xc_next;
            yc_reg            <= yc_next;
            c1_side_reg.lux   <= x_side_out.lux;
            c1_side_reg.neg   <= x_side_out.neg;
            c1_side_reg.undef <= x_dz;
            a_mag_reg         <= a_mag_next;
            d_mag_reg         <= d_mag_next;
            c2_side_reg       <= c2_side_next;
        end
    end

    // --------------------------------------------------------------
    // n = (xc - K1) / (K2 - yc)
    // --------------------------------------------------------------
    logic             nd_valid;
    logic [N_QB-1:0]  n_quo;
    logic             n_ovf, n_dz;
    ccm_side_t        n_side;

    ccm_div #(
        .NUM_W (N_NUM_W),
        .DEN_W (CH_MAG_W),
        .QB    (N_QB),
        .SW    (SIDE_W)
    ) u_div_n (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c2_valid_reg),
        .num       ({a_mag_reg, {FRAC_BITS{1'b0}}}),
        .den       (d_mag_reg),
        .side_in   (c2_side_reg),
        .out_valid (nd_valid),
        .quo       (n_quo),
        .ovf       (n_ovf),
        .dz        (n_dz),
        .side_out  (n_side)
    );

    // --------------------------------------------------------------
    // Cubic, scaling to kelvin, saturation and output register
    // --------------------------------------------------------------
    ccm_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (nd_valid),
        .q         (n_quo),
        .ovf       (n_ovf),
        .dz        (n_dz),
        .side      (n_side),
        .res_valid (res_valid),
        .res       (res)
    );

    // --------------------------------------------------------------
    // Checks
    // --------------------------------------------------------------
    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.temp_status == ST_UNDEF) |-> (res.color_temp == '0))
        else $error("undefined temperature must read as zero");

    a_status_value: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res.temp_status != ST_HIGH) || (res.color_temp == '1))
                   && ((res.temp_status != ST_LOW) || (res.color_temp == '0)))
        else $error("clamp status disagrees with temperature");

    a_lux_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.lux_clamped |-> (res.lux == '0) || (res.lux == '1))
        else $error("clamped lux must sit at a range limit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(c2_valid_reg) && $stable(a_mag_reg) && $stable(d_mag_reg))
        else $error("pipeline moved while held");

endmodule

FILE: tb/sv/tb_rgb_color_temperature_mccamy_top.sv
`timescale 1ns / 100ps

module tb_rgb_color_temperature_mccamy_top;
    import ccm_pkg::*;

    // Cycle budget: about 1250 requests, each with stalls and gaps,
    // plus the pipeline depth, taken many times over.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 150;
    localparam longint ONE_Q = 64'sd65536;
    localparam longint K1_Q = 64'sd21758;   // round(0.3320 * 2^16)
    localparam longint K2_Q = 64'sd12177;   // round(0.1858 * 2^16)
    localparam longint N_LIM = 64'sd127 * 64'sd65536;
    localparam longint XY_LIM = 64'sd2147483647;

    logic     clk;
    logic     rst_n;
    logic     pix_valid;
    logic     pix_stall;
    ccm_pix_t pix;
    logic     res_valid;
    logic     res_stall;
    ccm_res_t res;

    ccm_res_t expected_results[$];
    int       mismatches;
    int       cycles;
    bit       idle_enabled;
    int       holdoff_cycles;

    rgb_color_temperature_mccamy_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Saturate to the 16-bit unsigned range; flag says which side clipped.
    function automatic logic [15:0] sat_u16(input longint v, output ccm_status_t flag);
        flag = ST_OK;
        if (v < 0)
        begin
            flag = ST_LOW;
            return 16'd0;
        end
        if (v > 65535)
        begin
            flag = ST_HIGH;
            return 16'hFFFF;
        end
        return v[15:0];
    endfunction

    // Compute the CCT and lux that one RGB request must produce.
    function automatic ccm_res_t predict_cct(input ccm_pix_t p);
        longint r, g, b, x, y, z, s, xc, yc, d, n, n2, n3, poly;
        ccm_status_t flag;
        ccm_res_t o;
        r = longint'(p.red);
        g = longint'(p.green);
        b = longint'(p.blue);
        x = -2340 * r + 25383 * g - 15670 * b;
        y = -5319 * r + 25860 * g - 11992 * b;
        z = -11174 * r + 12628 * g + 9229 * b;
        s = x + y + z;
        o.lux = sat_u16(y / 16384, flag);
        o.lux_clamped = (flag != ST_OK);
        o.color_temp = 16'd0;
        o.temp_status = ST_UNDEF;
        if (s != 0)
        begin
            xc = clamp_sym((x * ONE_Q) / s, XY_LIM);
            yc = clamp_sym((y * ONE_Q) / s, XY_LIM);
            d = K2_Q - yc;
            if (d != 0)
            begin
                n = clamp_sym(((xc - K1_Q) * ONE_Q) / d, N_LIM);
                n2 = (n * n) / ONE_Q;
                n3 = (n2 * n) / ONE_Q;
                poly = 44900 * n3 + 352500 * n2 + 682330 * n + 552033 * ONE_Q;
                o.color_temp = sat_u16(poly / (100 * ONE_Q), flag);
                o.temp_status = flag;
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
        mismatches++;
    endtask

    // Offer one request; idle first at random, then hold it until accepted.
    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b);
        ccm_pix_t p;
        p.red = r;
        p.green = g;
        p.blue = b;
        while (idle_enabled && $urandom_range(99) < 26)
        begin
            pix_valid <= 1'b0;
            pix <= ccm_pix_t'({$urandom, 16'($urandom)});
            @(negedge clk);
        end
        pix <= p;
        pix_valid <= 1'b1;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        expected_results.push_back(predict_cct(p));
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_pixel(16'd0, 16'd0, 16'd0);            // zero sum: undefined
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd0, 16'd0);
        send_pixel(16'd0, 16'hFFFF, 16'd0);
        send_pixel(16'd0, 16'd0, 16'hFFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 16'd0);
        send_pixel(16'd0, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'd0, 16'hFFFF);
        send_pixel(16'd1, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd1, 16'd0);
        send_pixel(16'd0, 16'd0, 16'd1);
        send_pixel(16'd1, 16'd1, 16'd1);
        send_pixel(16'd1000, 16'd1000, 16'd1000);   // near-neutral light
        send_pixel(16'd3000, 16'd2000, 16'd1000);   // warm
        send_pixel(16'd1000, 16'd2000, 16'd3000);   // cool
        send_pixel(16'd0, 16'd1, 16'd1);            // small positive Y truncates to zero
        send_pixel(16'd2, 16'd1, 16'd0);
        send_pixel(16'h8000, 16'h7FFF, 16'h5555);
        send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
        send_pixel(16'd40000, 16'd100, 16'd40000);  // X, Y and Z all negative
    endtask

    // Mix of full-range, small, near-neutral, and strong-green triples with red and blue random or zero.
    task automatic send_random(input int count);
        logic [15:0] r, g, b;
        int base;
        repeat (count)
        begin
            case ($urandom_range(3))
                0:
                begin
                    r = 16'($urandom);
                    g = 16'($urandom);
                    b = 16'($urandom);
                end
                1:
                begin
                    r = 16'($urandom_range(15));
                    g = 16'($urandom_range(15));
                    b = 16'($urandom_range(15));
                end
                2:
                begin
                    base = $urandom_range(60000);
                    r = 16'(base + $urandom_range(3000));
                    g = 16'(base + $urandom_range(3000));
                    b = 16'(base + $urandom_range(3000));
                end
                default:
                begin
                    r = ($urandom_range(1) != 0) ? 16'($urandom) : 16'd0;
                    g = 16'($urandom_range(65535, 20000));
                    b = ($urandom_range(1) != 0) ? 16'($urandom) : 16'd0;
                end
            endcase
            send_pixel(r, g, b);
        end
    endtask

    task automatic test_random_idle();
        idle_enabled = 1'b1;
        send_random(700);
    endtask

    task automatic test_back_to_back();
        idle_enabled = 1'b0;
        send_random(300);
        idle_enabled = 1'b1;
    endtask

    // Hold the result side off long enough that the pipeline fills and
    // the input side has to stall.
    task automatic test_backpressure();
        holdoff_cycles = 400;
        send_random(230);
    endtask

    // Drive the result-side stall: long hold-off first, else random.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_cycles > 0)
            begin
                holdoff_cycles--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= idle_enabled && ($urandom_range(99) < 26);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycles);
                mismatches++;
            end
            else
            begin
                ccm_res_t want;
                want = expected_results.pop_front();
                if (res.color_temp !== want.color_temp)
                    report_mismatch("color_temp", res.color_temp, want.color_temp);
                if (res.temp_status !== want.temp_status)
                    report_mismatch("temp_status", res.temp_status, want.temp_status);
                if (res.lux !== want.lux)
                    report_mismatch("lux", res.lux, want.lux);
                if (res.lux_clamped !== want.lux_clamped)
                    report_mismatch("lux_clamped", res.lux_clamped, want.lux_clamped);
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_rgb_color_temperature_mccamy_top failed");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycles = 0;
        idle_enabled = 1'b1;
        holdoff_cycles = 0;
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_idle();
        test_back_to_back();
        test_backpressure();
        pix_valid <= 1'b0;

        // Drain, then let the pipeline settle to catch stray results.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_rgb_color_temperature_mccamy_top passed");
        else
            $display("tb_rgb_color_temperature_mccamy_top failed");
        $finish;
    end

endmodule
